// ===== hw/rtl/msp_pkg.sv =====
// shared types and constants for the mark slot pool
`default_nettype none
package msp_pkg;

    localparam int SLOT_COUNT_DEF = 128;

    // operation codes
    localparam logic [1:0] OP_ADD  = 2'd0;
    localparam logic [1:0] OP_TICK = 2'd1;
    localparam logic [1:0] OP_READ = 2'd2;
    localparam logic [1:0] OP_NONE = 2'd3;

    // register indexes
    localparam logic REG_TOLERANCE = 1'b0;
    localparam logic REG_FLOOR     = 1'b1;

    localparam logic [15:0] TOLERANCE_RESET = 16'd16;
    localparam logic [15:0] FLOOR_RESET     = 16'h1000;
    localparam logic [15:0] AGE_MAX         = 16'hFFFF;

    // one stored slot
    typedef struct packed {
        logic [15:0]        owner;
        logic [7:0]         mark_id;
        logic signed [19:0] pos_x;
        logic signed [19:0] pos_z;
        logic [15:0]        alpha;
        logic [15:0]        step;
        logic [15:0]        delay;
        logic [15:0]        age;
    } entry_t;

    // evaluation of one slot by the shared unit
    typedef struct packed {
        logic   same;
        logic   near;
        logic   active;
        logic   freed;
        entry_t aged;
    } slot_eval_t;

endpackage
`default_nettype wire

// ===== hw/rtl/msp_slot_unit.sv =====
// shared compare and fade unit, evaluates one slot per cycle
`default_nettype none
module msp_slot_unit (
    input  msp_pkg::entry_t     ent,
    input  logic                live,
    input  logic                fading,
    input  logic [15:0]         owner,
    input  logic [7:0]          mark_id,
    input  logic signed [19:0]  pos_x,
    input  logic signed [19:0]  pos_z,
    input  logic [15:0]         tolerance,
    input  logic [15:0]         floor_val,
    output msp_pkg::slot_eval_t ev
);

    logic signed [20:0] dx;
    logic signed [20:0] dz;
    logic [20:0]        adx;
    logic [20:0]        adz;
    logic [16:0]        need;
    logic               keep;

    // distance on both axes
    assign dx  = {ent.pos_x[19], ent.pos_x} - {pos_x[19], pos_x};
    assign dz  = {ent.pos_z[19], ent.pos_z} - {pos_z[19], pos_z};
    assign adx = dx[20] ? 21'(-dx) : 21'(dx);
    assign adz = dz[20] ? 21'(-dz) : 21'(dz);

    // alpha margin check without overflow
    assign need = {1'b0, ent.step} + {1'b0, floor_val};
    assign keep = {1'b0, ent.alpha} >= need;

    always_comb
    begin
        ev.same   = live && !fading && (ent.owner == owner) && (ent.mark_id == mark_id);
        ev.near   = (adx <= {5'b0, tolerance}) && (adz <= {5'b0, tolerance});
        ev.active = live && fading;
        ev.freed  = live && fading && (ent.delay == 16'd0) && !keep;
        ev.aged   = ent;
        if (ent.age != msp_pkg::AGE_MAX)
        begin
            ev.aged.age = ent.age + 16'd1;
        end
        if (ent.delay != 16'd0)
        begin
            ev.aged.delay = ent.delay - 16'd1;
        end
        else if (keep)
        begin
            ev.aged.alpha = ent.alpha - ent.step;
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/mark_slot_pool_with_fade.sv =====
// top level of the mark slot pool with fade
// Add and tick walk the whole pool one slot per cycle through a single read port of the
// slot memory and one shared compare and fade unit; an add that finds a nearby
// duplicate ends at that slot, a read holds busy high for one cycle and an unused op
// does not raise busy at all. Done rises in the same cycle that busy falls, or straight
// after an unused op is taken. start is taken only while busy is low. The result is
// shown for exactly one cycle with done high and cannot be held off.
// No clearing pass is needed after reset; configuration is written over the APB port.
`default_nettype none
module mark_slot_pool_with_fade #(
    parameter int SLOT_COUNT = msp_pkg::SLOT_COUNT_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic [1:0]         op,
    input  wire logic [15:0]        owner,
    input  wire logic [7:0]         mark_id,
    input  wire logic signed [19:0] pos_x,
    input  wire logic signed [19:0] pos_z,
    input  wire logic [15:0]        start_alpha,
    input  wire logic [15:0]        alpha_step,
    input  wire logic [15:0]        fade_delay,
    input  wire logic [6:0]         slot_index,
    output logic                    done,
    output logic [6:0]              written_slot,
    output logic                    written,
    output logic                    duplicate,
    output logic [7:0]              freed_count,
    output logic                    slot_valid,
    output logic                    slot_fading,
    output logic [15:0]             slot_alpha,
    output logic [15:0]             slot_owner,
    output logic [7:0]              slot_mark_id,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [2:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);

    localparam int IW = $clog2(SLOT_COUNT);
    localparam int CW = $clog2(SLOT_COUNT + 1);
    localparam int EW = $bits(msp_pkg::entry_t);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_SCAN = 4'b0010,
        ST_FILL = 4'b0100,
        ST_READ = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    // captured transaction
    logic [1:0]         op_reg;
    logic [15:0]        owner_reg;
    logic [7:0]         id_reg;
    logic signed [19:0] x_reg;
    logic signed [19:0] z_reg;
    logic [15:0]        alpha_reg;
    logic [15:0]        step_reg;
    logic [15:0]        delay_reg;
    logic [IW-1:0]      idx_reg;
    logic               inrange_reg;

    // scan control
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          pv_reg, pv_next;
    logic [IW-1:0] pidx_reg, pidx_next;
    logic          have_free_reg, have_free_next;
    logic [IW-1:0] dest_reg, dest_next;
    logic          have_old_reg, have_old_next;
    logic [IW-1:0] oldest_reg, oldest_next;
    logic [15:0]   oldest_age_reg, oldest_age_next;
    logic [CW-1:0] freed_reg, freed_next;

    // per slot flags
    logic [SLOT_COUNT-1:0] in_use_reg, in_use_next;
    logic [SLOT_COUNT-1:0] fading_reg, fading_next;

    // configuration
    logic [15:0] tol_reg;
    logic [15:0] floor_reg;

    // result registers
    logic        done_reg, done_next;
    logic [6:0]  wslot_reg, wslot_next;
    logic        written_reg, written_next;
    logic        dup_reg, dup_next;
    logic [7:0]  freed_out_reg, freed_out_next;
    logic        sv_reg, sv_next;
    logic        sf_reg, sf_next;
    logic [15:0] sa_reg, sa_next;
    logic [15:0] so_reg, so_next;
    logic [7:0]  sm_reg, sm_next;

    // slot memory
    logic [EW-1:0]       mem [SLOT_COUNT];
    logic                mem_we;
    logic [IW-1:0]       mem_waddr;
    logic [EW-1:0]       mem_wdata;
    logic [IW-1:0]       mem_raddr;
    msp_pkg::entry_t     rdata_reg;
    msp_pkg::entry_t     fill_ent;
    msp_pkg::slot_eval_t ev;

    logic take;
    logic cfg_wr;

    assign take   = start && (state_reg == ST_IDLE);
    assign cfg_wr = psel && penable && pwrite;

    // memory, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= msp_pkg::entry_t'(mem[mem_raddr]);
    end

    assign mem_raddr = (state_reg == ST_SCAN) ? cnt_reg[IW-1:0] : IW'(slot_index);

    msp_slot_unit u_unit (
        .ent       (rdata_reg),
        .live      (in_use_reg[pidx_reg]),
        .fading    (fading_reg[pidx_reg]),
        .owner     (owner_reg),
        .mark_id   (id_reg),
        .pos_x     (x_reg),
        .pos_z     (z_reg),
        .tolerance (tol_reg),
        .floor_val (floor_reg),
        .ev        (ev)
    );

    // new entry for a fill
    always_comb
    begin
        fill_ent.owner   = owner_reg;
        fill_ent.mark_id = id_reg;
        fill_ent.pos_x   = x_reg;
        fill_ent.pos_z   = z_reg;
        fill_ent.alpha   = alpha_reg;
        fill_ent.step    = step_reg;
        fill_ent.delay   = delay_reg;
        fill_ent.age     = 16'd0;
    end

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        pv_next         = 1'b0;
        pidx_next       = pidx_reg;
        have_free_next  = have_free_reg;
        dest_next       = dest_reg;
        have_old_next   = have_old_reg;
        oldest_next     = oldest_reg;
        oldest_age_next = oldest_age_reg;
        freed_next      = freed_reg;
        in_use_next     = in_use_reg;
        fading_next     = fading_reg;
        done_next       = 1'b0;
        wslot_next      = wslot_reg;
        written_next    = written_reg;
        dup_next        = dup_reg;
        freed_out_next  = freed_out_reg;
        sv_next         = sv_reg;
        sf_next         = sf_reg;
        sa_next         = sa_reg;
        so_next         = so_reg;
        sm_next         = sm_reg;
        mem_we          = 1'b0;
        mem_waddr       = pidx_reg;
        mem_wdata       = EW'(ev.aged);

        unique case (state_reg)
            ST_IDLE:
            begin
                if (take)
                begin
                    wslot_next     = 7'd0;
                    written_next   = 1'b0;
                    dup_next       = 1'b0;
                    freed_out_next = 8'd0;
                    sv_next        = 1'b0;
                    sf_next        = 1'b0;
                    sa_next        = 16'd0;
                    so_next        = 16'd0;
                    sm_next        = 8'd0;
                    cnt_next       = '0;
                    have_free_next = 1'b0;
                    have_old_next  = 1'b0;
                    freed_next     = '0;
                    case (op) inside
                        msp_pkg::OP_ADD, msp_pkg::OP_TICK: state_next = ST_SCAN;
                        msp_pkg::OP_READ:                  state_next = ST_READ;
                        default:                           done_next  = 1'b1;
                    endcase
                end
            end

            ST_SCAN:
            begin
                // issue the next slot read
                if (cnt_reg < CW'(SLOT_COUNT))
                begin
                    cnt_next  = cnt_reg + CW'(1);
                    pv_next   = 1'b1;
                    pidx_next = cnt_reg[IW-1:0];
                end
                // work on the slot read last cycle
                if (pv_reg)
                begin
                    if (op_reg == msp_pkg::OP_ADD)
                    begin
                        if (ev.same && ev.near)
                        begin
                            dup_next   = 1'b1;
                            done_next  = 1'b1;
                            pv_next    = 1'b0;
                            state_next = ST_IDLE;
                        end
                        else
                        begin
                            if (ev.same)
                            begin
                                fading_next[pidx_reg] = 1'b1;
                            end
                            if (!in_use_reg[pidx_reg])
                            begin
                                have_free_next = 1'b1;
                                dest_next      = pidx_reg;
                            end
                            else if (!have_old_reg || (rdata_reg.age > oldest_age_reg))
                            begin
                                have_old_next   = 1'b1;
                                oldest_next     = pidx_reg;
                                oldest_age_next = rdata_reg.age;
                            end
                        end
                    end
                    else if (ev.active)
                    begin
                        mem_we = 1'b1;
                        if (ev.freed)
                        begin
                            in_use_next[pidx_reg] = 1'b0;
                            freed_next            = freed_reg + CW'(1);
                        end
                    end
                end
                else if (cnt_reg == CW'(SLOT_COUNT))
                begin
                    // whole pool seen
                    if (op_reg == msp_pkg::OP_ADD)
                    begin
                        state_next = ST_FILL;
                    end
                    else
                    begin
                        freed_out_next = 8'(freed_reg);
                        done_next      = 1'b1;
                        state_next     = ST_IDLE;
                    end
                end
            end

            ST_FILL:
            begin
                mem_we    = 1'b1;
                mem_waddr = have_free_reg ? dest_reg : oldest_reg;
                mem_wdata = EW'(fill_ent);
                in_use_next[mem_waddr] = 1'b1;
                fading_next[mem_waddr] = 1'b0;
                wslot_next   = 7'(mem_waddr);
                written_next = 1'b1;
                done_next    = 1'b1;
                state_next   = ST_IDLE;
            end

            ST_READ:
            begin
                if (inrange_reg && in_use_reg[idx_reg])
                begin
                    sv_next = 1'b1;
                    sf_next = fading_reg[idx_reg];
                    sa_next = rdata_reg.alpha;
                    so_next = rdata_reg.owner;
                    sm_next = rdata_reg.mark_id;
                end
                done_next  = 1'b1;
                state_next = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            cnt_reg    <= '0;
            pv_reg     <= 1'b0;
            in_use_reg <= '0;
            fading_reg <= '0;
            done_reg   <= 1'b0;
            tol_reg    <= msp_pkg::TOLERANCE_RESET;
            floor_reg  <= msp_pkg::FLOOR_RESET;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            pv_reg     <= pv_next;
            in_use_reg <= in_use_next;
            fading_reg <= fading_next;
            done_reg   <= done_next;
            if (cfg_wr)
            begin
                unique case (paddr[2])
                    msp_pkg::REG_TOLERANCE: tol_reg   <= pwdata[15:0];
                    msp_pkg::REG_FLOOR:     floor_reg <= pwdata[15:0];
                    default:                tol_reg   <= tol_reg;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            op_reg      <= op;
            owner_reg   <= owner;
            id_reg      <= mark_id;
            x_reg       <= pos_x;
            z_reg       <= pos_z;
            alpha_reg   <= start_alpha;
            step_reg    <= alpha_step;
            delay_reg   <= fade_delay;
            idx_reg     <= IW'(slot_index);
            inrange_reg <= 32'(slot_index) < SLOT_COUNT;
        end
        pidx_reg       <= pidx_next;
        have_free_reg  <= have_free_next;
        dest_reg       <= dest_next;
        have_old_reg   <= have_old_next;
        oldest_reg     <= oldest_next;
        oldest_age_reg <= oldest_age_next;
        freed_reg      <= freed_next;
        wslot_reg      <= wslot_next;
        written_reg    <= written_next;
        dup_reg        <= dup_next;
        freed_out_reg  <= freed_out_next;
        sv_reg         <= sv_next;
        sf_reg         <= sf_next;
        sa_reg         <= sa_next;
        so_reg         <= so_next;
        sm_reg         <= sm_next;
    end

    // ports
    assign busy         = (state_reg != ST_IDLE);
    assign done         = done_reg;
    assign written_slot = wslot_reg;
    assign written      = written_reg;
    assign duplicate    = dup_reg;
    assign freed_count  = freed_out_reg;
    assign slot_valid   = sv_reg;
    assign slot_fading  = sf_reg;
    assign slot_alpha   = sa_reg;
    assign slot_owner   = so_reg;
    assign slot_mark_id = sm_reg;
    assign pready       = 1'b1;
    assign prdata       = (paddr[2] == msp_pkg::REG_FLOOR) ? {16'd0, floor_reg}
                                                           : {16'd0, tol_reg};

endmodule
`default_nettype wire

// ===== hw/rtl/msp_checker.sv =====
// port level checks for the mark slot pool, bound to the top level
`default_nettype none
module msp_checker #(
    parameter int SLOT_COUNT = msp_pkg::SLOT_COUNT_DEF
) (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       start,
    input wire logic       busy,
    input wire logic       done,
    input wire logic       written,
    input wire logic       duplicate,
    input wire logic [6:0] written_slot,
    input wire logic       slot_valid,
    input wire logic [1:0] op
);

    // a taken transaction with a real op makes the block busy
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && (op != msp_pkg::OP_NONE) |=> busy)
        else $error("not busy after start");

    // results only appear once the block is idle again
    a_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy) else $error("done while busy");

    // an add either stores or matches, never both
    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !(written && duplicate)) else $error("written and duplicate together");

    // a stored mark lands inside the pool
    a_slot: assert property (@(posedge clk) disable iff (!rst_n)
        done && written |-> (32'(written_slot) < SLOT_COUNT))
        else $error("written slot out of range");

    // unused op gives an empty result in the next cycle
    a_unused: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && (op == msp_pkg::OP_NONE) |=> done && !written && !slot_valid)
        else $error("unused op result not empty");

endmodule

bind mark_slot_pool_with_fade msp_checker #(.SLOT_COUNT(SLOT_COUNT)) u_msp_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .done         (done),
    .written      (written),
    .duplicate    (duplicate),
    .written_slot (written_slot),
    .slot_valid   (slot_valid),
    .op           (op)
);
`default_nettype wire

// ===== tb/tb_mark_slot_pool_with_fade.sv =====
// self-checking testbench for the mark slot pool with fade
`default_nettype none
module tb_mark_slot_pool_with_fade;
    import msp_pkg::*;

    localparam int CYCLE_LIMIT = 2000000;
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic [1:0]         op;
        logic [15:0]        owner;
        logic [7:0]         mark_id;
        logic signed [19:0] pos_x;
        logic signed [19:0] pos_z;
        logic [15:0]        start_alpha;
        logic [15:0]        alpha_step;
        logic [15:0]        fade_delay;
        logic [6:0]         slot_index;
    } pool_cmd_t;

    typedef struct packed {
        logic [6:0]  written_slot;
        logic        written;
        logic        duplicate;
        logic [7:0]  freed_count;
        logic        slot_valid;
        logic        slot_fading;
        logic [15:0] slot_alpha;
        logic [15:0] slot_owner;
        logic [7:0]  slot_mark_id;
    } pool_resp_t;

    // mirror of the slot pool and its queue of pending responses
    class pool_scoreboard;
        logic [15:0]        tolerance;
        logic [15:0]        floor_level;
        bit                 live [SLOT_COUNT_DEF];
        bit                 fading [SLOT_COUNT_DEF];
        logic [15:0]        own [SLOT_COUNT_DEF];
        logic [7:0]         ident [SLOT_COUNT_DEF];
        logic signed [19:0] px [SLOT_COUNT_DEF];
        logic signed [19:0] pz [SLOT_COUNT_DEF];
        logic [15:0]        alpha [SLOT_COUNT_DEF];
        logic [15:0]        step [SLOT_COUNT_DEF];
        logic [15:0]        delay [SLOT_COUNT_DEF];
        logic [15:0]        age [SLOT_COUNT_DEF];
        pool_resp_t         pending [$];
        int                 mismatches;

        function new();
            tolerance = TOLERANCE_RESET;
            floor_level = FLOOR_RESET;
            mismatches = 0;
            for (int i = 0; i < SLOT_COUNT_DEF; i++)
            begin
                live[i] = 0;
                fading[i] = 0;
            end
        endfunction

        function void set_register(logic idx, logic [15:0] value);
            if (idx == REG_TOLERANCE)
                tolerance = value;
            else
                floor_level = value;
        endfunction

        function bit close_by(logic signed [19:0] a, logic signed [19:0] b);
            int d;
            d = int'(a) - int'(b);
            if (d < 0)
                d = -d;
            return d <= int'(tolerance);
        endfunction

        // work out the response of one accepted transaction and update the mirror
        function void note_command(pool_cmd_t c);
            pool_resp_t r;
            bit have_free;
            bit have_old;
            int dest;
            int oldest;
            int freed;
            r = '0;
            have_free = 0;
            have_old = 0;
            dest = 0;
            oldest = 0;
            freed = 0;
            case (c.op)
                OP_ADD:
                begin
                    for (int i = 0; i < SLOT_COUNT_DEF; i++)
                    begin
                        if (live[i] && !fading[i] && own[i] == c.owner
                            && ident[i] == c.mark_id)
                        begin
                            if (close_by(px[i], c.pos_x) && close_by(pz[i], c.pos_z))
                            begin
                                r.duplicate = 1;
                                break;
                            end
                            fading[i] = 1;
                        end
                        if (!live[i])
                        begin
                            have_free = 1;
                            dest = i;
                        end
                        else if (!have_old || age[i] > age[oldest])
                        begin
                            have_old = 1;
                            oldest = i;
                        end
                    end
                    if (!r.duplicate)
                    begin
                        if (!have_free)
                            dest = oldest;
                        live[dest] = 1;
                        fading[dest] = 0;
                        own[dest] = c.owner;
                        ident[dest] = c.mark_id;
                        px[dest] = c.pos_x;
                        pz[dest] = c.pos_z;
                        alpha[dest] = c.start_alpha;
                        step[dest] = c.alpha_step;
                        delay[dest] = c.fade_delay;
                        age[dest] = 0;
                        r.written_slot = 7'(dest);
                        r.written = 1;
                    end
                end
                OP_TICK:
                begin
                    for (int i = 0; i < SLOT_COUNT_DEF; i++)
                    begin
                        if (!live[i] || !fading[i])
                            continue;
                        if (age[i] != AGE_MAX)
                            age[i] = age[i] + 16'd1;
                        if (delay[i] != 0)
                            delay[i] = delay[i] - 16'd1;
                        else if ({1'b0, alpha[i]} >= {1'b0, step[i]} + {1'b0, floor_level})
                            alpha[i] = alpha[i] - step[i];
                        else
                        begin
                            live[i] = 0;
                            freed++;
                        end
                    end
                    r.freed_count = 8'(freed);
                end
                OP_READ:
                begin
                    if (live[c.slot_index])
                    begin
                        r.slot_valid = 1;
                        r.slot_fading = fading[c.slot_index];
                        r.slot_alpha = alpha[c.slot_index];
                        r.slot_owner = own[c.slot_index];
                        r.slot_mark_id = ident[c.slot_index];
                    end
                end
                default: ;
            endcase
            pending.push_back(r);
        endfunction

        // compare one response with the oldest pending one
        function void check_response(pool_resp_t got);
            pool_resp_t exp;
            if (pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected response %h", got);
                return;
            end
            exp = pending.pop_front();
            if (got.written_slot != exp.written_slot || got.written != exp.written
                || got.duplicate != exp.duplicate || got.freed_count != exp.freed_count
                || got.slot_valid != exp.slot_valid || got.slot_fading != exp.slot_fading
                || got.slot_alpha != exp.slot_alpha || got.slot_owner != exp.slot_owner
                || got.slot_mark_id != exp.slot_mark_id)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("mismatch: exp slot=%0d wr=%0d dup=%0d freed=%0d ",
                        exp.written_slot, exp.written, exp.duplicate, exp.freed_count,
                        "v=%0d f=%0d a=%h o=%h id=%h",
                        exp.slot_valid, exp.slot_fading, exp.slot_alpha, exp.slot_owner,
                        exp.slot_mark_id,
                        " | got slot=%0d wr=%0d dup=%0d freed=%0d ",
                        got.written_slot, got.written, got.duplicate, got.freed_count,
                        "v=%0d f=%0d a=%h o=%h id=%h",
                        got.slot_valid, got.slot_fading, got.slot_alpha, got.slot_owner,
                        got.slot_mark_id);
            end
        endfunction
    endclass

    logic               clk = 0;
    logic               rst_n = 0;
    logic               start = 0;
    logic               busy;
    logic               done;
    pool_cmd_t          cmd = '0;
    pool_resp_t         resp;
    logic               psel = 0;
    logic               penable = 0;
    logic               pwrite = 0;
    logic [2:0]         paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;
    int                 cycles = 0;
    int                 idle_pct = 0;
    pool_scoreboard     sb;

    mark_slot_pool_with_fade DUT (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .op(cmd.op), .owner(cmd.owner), .mark_id(cmd.mark_id),
        .pos_x(cmd.pos_x), .pos_z(cmd.pos_z), .start_alpha(cmd.start_alpha),
        .alpha_step(cmd.alpha_step), .fade_delay(cmd.fade_delay),
        .slot_index(cmd.slot_index), .done(done),
        .written_slot(resp.written_slot), .written(resp.written),
        .duplicate(resp.duplicate), .freed_count(resp.freed_count),
        .slot_valid(resp.slot_valid), .slot_fading(resp.slot_fading),
        .slot_alpha(resp.slot_alpha), .slot_owner(resp.slot_owner),
        .slot_mark_id(resp.slot_mark_id),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #4 clk = ~clk;

    // note accepted transactions and check responses
    always @(posedge clk)
    begin
        if (rst_n && start && !busy)
            sb.note_command(cmd);
        if (rst_n && done)
            sb.check_response(resp);
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("[mark_slot_pool_with_fade] ERROR");
            $finish;
        end
    end

    // present one transaction and hold it until taken, then maybe idle
    task automatic send(pool_cmd_t c);
        start <= 1'b1;
        cmd <= c;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        if ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    endtask

    // register write once the pool is quiet
    task automatic write_reg(logic idx, logic [15:0] value);
        start <= 1'b0;
        @(posedge clk);
        while (busy || sb.pending.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= {idx, 2'b00};
        pwdata <= {$urandom_range(65535), value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        sb.set_register(idx, value);
    endtask

    function automatic pool_cmd_t add_cmd(logic [15:0] o, logic [7:0] id,
                                          logic signed [19:0] x, logic signed [19:0] z);
        pool_cmd_t c;
        c = '0;
        c.op = OP_ADD;
        c.owner = o;
        c.mark_id = id;
        c.pos_x = x;
        c.pos_z = z;
        c.start_alpha = 16'($urandom_range(65535));
        c.alpha_step = ($urandom_range(3) == 0) ? 16'($urandom_range(65535))
                                                 : 16'($urandom_range(3000));
        c.fade_delay = ($urandom_range(9) == 0) ? 16'($urandom_range(65535))
                                                 : 16'($urandom_range(3));
        c.slot_index = 7'($urandom_range(127));
        return c;
    endfunction

    function automatic pool_cmd_t other_cmd(logic [1:0] o);
        pool_cmd_t c;
        c = pool_cmd_t'($bits(pool_cmd_t)'({$urandom, $urandom, $urandom, $urandom,
                                            $urandom}));
        c.op = o;
        if (o == OP_READ && $urandom_range(3) != 0)
            c.slot_index = 7'($urandom_range(96, 127));
        return c;
    endfunction

    // one phase of random traffic, led by clustered marks that collide and fade
    task automatic random_phase(int count, bit fill_burst);
        int k;
        logic signed [19:0] bx;
        logic signed [19:0] bz;
        if (fill_burst)
            for (int i = 0; i < 140; i++)
                send(add_cmd(16'(1000 + i), 8'(i), 20'($urandom), 20'($urandom)));
        for (int n = 0; n < count; n++)
        begin
            k = $urandom_range(99);
            bx = 20'(($urandom_range(3) - 1) * 64 + $urandom_range(40) - 20);
            bz = 20'(($urandom_range(3) - 1) * 64 + $urandom_range(40) - 20);
            if (k < 40)
                send(add_cmd(16'($urandom_range(1, 6)), 8'($urandom_range(3)), bx, bz));
            else if (k < 50)
                send(add_cmd(16'($urandom), 8'($urandom), 20'($urandom), 20'($urandom)));
            else if (k < 75)
                send(other_cmd(OP_TICK));
            else if (k < 95)
                send(other_cmd(OP_READ));
            else
                send(other_cmd(OP_NONE));
        end
    endtask

    initial
    begin
        pool_cmd_t c;
        sb = new();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes, duplicate, fade, reads, unused op
        c = add_cmd(16'hFFFF, 8'hFF, -20'sd524288, 20'sd524287);
        c.start_alpha = 16'hFFFF;
        c.alpha_step = 16'hFFFF;
        c.fade_delay = 16'hFFFF;
        send(c);
        c = add_cmd(16'd0, 8'd0, 20'sd524287, -20'sd524288);
        c.start_alpha = 16'h0000;
        c.alpha_step = 16'h0000;
        c.fade_delay = 16'h0000;
        send(c);
        c = add_cmd(16'd5, 8'd7, 20'sd100, 20'sd100);
        c.start_alpha = 16'h3000;
        c.alpha_step = 16'h0800;
        c.fade_delay = 16'd1;
        send(c);
        send(add_cmd(16'd5, 8'd7, 20'sd116, 20'sd84));
        send(add_cmd(16'd5, 8'd7, 20'sd117, 20'sd100));
        send(add_cmd(16'd0, 8'd0, 20'sd0, 20'sd0));
        for (int i = 0; i < 6; i++)
        begin
            send(other_cmd(OP_TICK));
            c = other_cmd(OP_READ);
            c.slot_index = 7'(127 - (i % 4));
            send(c);
        end
        c = other_cmd(OP_READ);
        c.slot_index = 7'd0;
        send(c);
        send(other_cmd(OP_NONE));

        idle_pct = 26;
        random_phase(300, 0);
        write_reg(REG_TOLERANCE, 16'd0);
        write_reg(REG_FLOOR, 16'd0);
        random_phase(150, 0);
        idle_pct = 55;
        write_reg(REG_TOLERANCE, 16'hFFFF);
        write_reg(REG_FLOOR, 16'hFFFF);
        random_phase(300, 1);
        idle_pct = 0;
        write_reg(REG_TOLERANCE, 16'($urandom_range(200)));
        write_reg(REG_FLOOR, 16'($urandom_range(8192)));
        random_phase(250, 0);
        write_reg(REG_TOLERANCE, TOLERANCE_RESET);
        write_reg(REG_FLOOR, FLOOR_RESET);
        random_phase(150, 0);

        // drain
        start <= 1'b0;
        @(posedge clk);
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (2 * SLOT_COUNT_DEF) @(posedge clk);
        if (sb.mismatches == 0)
            $display("[mark_slot_pool_with_fade] OK");
        else
            $display("[mark_slot_pool_with_fade] ERROR");
        $finish;
    end
endmodule
`default_nettype wire

// ===== sim.f =====
hw/rtl/msp_pkg.sv
hw/rtl/msp_slot_unit.sv
hw/rtl/mark_slot_pool_with_fade.sv
hw/rtl/msp_checker.sv
tb/tb_mark_slot_pool_with_fade.sv
